// ===== design/pmtu_pkg.sv =====
// pmtu_pkg: shared types and constants of the path-MTU probe search controller
// request, result, configuration and snapshot types, mode and command codes
// no dependencies
package pmtu_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned MtuWidth  = 16;
  localparam int unsigned CntWidth  = 8;
  localparam int unsigned CmdWidth  = 4;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned ModeCodeWidth = 3;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [MtuWidth-1:0]  mtu_t;
  typedef logic [CntWidth-1:0]  cnt_t;

  // command codes of a request
  typedef enum logic [CmdWidth-1:0] {
    CmdEnable  = 4'd0,
    CmdDisable = 4'd1,
    CmdReset   = 4'd2,
    CmdSent    = 4'd3,
    CmdAcked   = 4'd4,
    CmdLost    = 4'd5,
    CmdTooBig  = 4'd6,
    CmdTimeout = 4'd7,
    CmdPoll    = 4'd8
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMinMtu       = 3'd0,
    CfgMaxProbeMtu  = 3'd1,
    CfgProbeStep    = 3'd2,
    CfgMaxProbes    = 3'd3,
    CfgProbeIntv    = 3'd4,
    CfgProbeTimeout = 3'd5,
    CfgConfirmIntv  = 3'd6,
    CfgBlackHoleThr = 3'd7
  } cfg_idx_e;

  // controller mode, one-hot
  typedef enum logic [4:0] {
    ModeDisabled  = 5'b00001,
    ModeBase      = 5'b00010,
    ModeSearching = 5'b00100,
    ModeComplete  = 5'b01000,
    ModeError     = 5'b10000
  } mode_e;

  // mode codes as reported in a result
  localparam logic [ModeCodeWidth-1:0] ModeCodeDisabled  = 3'd0;
  localparam logic [ModeCodeWidth-1:0] ModeCodeBase      = 3'd1;
  localparam logic [ModeCodeWidth-1:0] ModeCodeSearching = 3'd2;
  localparam logic [ModeCodeWidth-1:0] ModeCodeComplete  = 3'd3;
  localparam logic [ModeCodeWidth-1:0] ModeCodeError     = 3'd4;

  // reset values of the configuration registers
  localparam mtu_t  MinMtuRst       = 16'd1200;
  localparam mtu_t  MaxProbeMtuRst  = 16'd1500;
  localparam mtu_t  ProbeStepRst    = 16'd16;
  localparam cnt_t  MaxProbesRst    = 8'd3;
  localparam time_t ProbeIntvRst    = 32'd1000;
  localparam time_t ProbeTimeoutRst = 32'd3000;
  localparam time_t ConfirmIntvRst  = 32'd600000;
  localparam cnt_t  BlackHoleThrRst = 8'd3;

  typedef struct packed {
    logic [CmdWidth-1:0] cmd;
    mtu_t                size;
    time_t               now;
  } in_req_t;

  typedef struct packed {
    logic [ModeCodeWidth-1:0] mode;
    mtu_t                     current_mtu;
    logic                     probe_valid;
    mtu_t                     probe_bytes;
    logic                     probe_now;
    logic                     in_flight;
    logic                     deadline_valid;
    time_t                    deadline;
  } out_rsp_t;

  typedef struct packed {
    mtu_t  min_mtu;
    mtu_t  mtu_ceiling;
    mtu_t  conv_width;
    cnt_t  retry_limit;
    time_t probe_gap;
    time_t loss_wait;
    time_t revalidate_gap;
    cnt_t  black_hole_threshold;
  } cfg_t;

  // controller state after one request, handed to the status stage
  typedef struct packed {
    mode_e mode;
    mtu_t  validated_mtu;
    mtu_t  probing_size;
    logic  probe_pending;
    time_t last_probe_at;
    time_t completed_at;
    time_t now;
  } snap_t;

endpackage

// ===== design/pmtu_cfg.sv =====
// pmtu_cfg: configuration register file of the probe search controller
// depends on pmtu_pkg
module pmtu_cfg import pmtu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_mtu              <= MinMtuRst;
      cfg_q.mtu_ceiling          <= MaxProbeMtuRst;
      cfg_q.conv_width           <= ProbeStepRst;
      cfg_q.retry_limit          <= MaxProbesRst;
      cfg_q.probe_gap            <= ProbeIntvRst;
      cfg_q.loss_wait            <= ProbeTimeoutRst;
      cfg_q.revalidate_gap       <= ConfirmIntvRst;
      cfg_q.black_hole_threshold <= BlackHoleThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMinMtu:       cfg_q.min_mtu              <= cfg_wdata_i[MtuWidth-1:0];
        CfgMaxProbeMtu:  cfg_q.mtu_ceiling          <= cfg_wdata_i[MtuWidth-1:0];
        CfgProbeStep:    cfg_q.conv_width           <= cfg_wdata_i[MtuWidth-1:0];
        CfgMaxProbes:    cfg_q.retry_limit          <= cfg_wdata_i[CntWidth-1:0];
        CfgProbeIntv:    cfg_q.probe_gap            <= cfg_wdata_i[TimeWidth-1:0];
        CfgProbeTimeout: cfg_q.loss_wait            <= cfg_wdata_i[TimeWidth-1:0];
        CfgConfirmIntv:  cfg_q.revalidate_gap       <= cfg_wdata_i[TimeWidth-1:0];
        CfgBlackHoleThr: cfg_q.black_hole_threshold <= cfg_wdata_i[CntWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pmtu_ctrl.sv =====
// pmtu_ctrl: request register and state update of the probe search controller
// applies one request per cycle unless stalled; hands new state on as snapshot
// depends on pmtu_pkg
module pmtu_ctrl import pmtu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    snap_valid_o,
  input  logic    snap_stall_i,
  output snap_t   snap_o
);

  typedef struct packed {
    mode_e mode;
    mtu_t  vmtu;
    mtu_t  wlo;
    mtu_t  whi;
    mtu_t  psize;
    cnt_t  retry;
    cnt_t  streak;
    logic  pending;
    time_t last_at;
    time_t comp_at;
  } state_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == {CntWidth{1'b1}}) ? v : cnt_t'(v + 1'b1);
  endfunction

  // inverted window counts as converged
  function automatic logic converged(mtu_t lo, mtu_t hi, mtu_t step);
    return (hi < lo) || (mtu_t'(hi - lo) <= step);
  endfunction

  function automatic mtu_t next_size(mtu_t lo, mtu_t hi, mtu_t step);
    logic [MtuWidth:0] mid;
    mtu_t              res;
    mid = '0;
    if (hi <= lo) begin
      res = hi;
    end else begin
      mid = {1'b0, lo} + {1'b0, mtu_t'(mtu_t'(hi - lo) >> 1)};
      if (mid[MtuWidth-1:0] == lo) begin
        mid = {1'b0, lo} + {1'b0, step};
      end
      res = (mid < {1'b0, hi}) ? mid[MtuWidth-1:0] : hi;
    end
    return res;
  endfunction

  function automatic logic is_active(mode_e m);
    return (m == ModeBase) || (m == ModeSearching);
  endfunction

  function automatic state_t close_search(state_t s, time_t now);
    state_t r;
    r         = s;
    r.mode    = ModeComplete;
    r.comp_at = now;
    r.psize   = '0;
    r.retry   = '0;
    return r;
  endfunction

  function automatic state_t black_hole(state_t s, cfg_t c);
    state_t r;
    r         = s;
    r.mode    = ModeError;
    r.vmtu    = c.min_mtu;
    r.wlo     = c.min_mtu;
    r.whi     = c.mtu_ceiling;
    r.psize   = '0;
    r.retry   = '0;
    r.streak  = '0;
    r.pending = 1'b0;
    return r;
  endfunction

  function automatic state_t lost(state_t s, mtu_t size, time_t now, cfg_t c);
    state_t r;
    r         = s;
    r.pending = 1'b0;
    r.streak  = sat_inc(s.streak);
    if (r.streak >= c.black_hole_threshold) begin
      r = black_hole(r, c);
    end else if (is_active(r.mode)) begin
      if (r.retry >= c.retry_limit) begin
        r.whi   = size;
        r.retry = '0;
        if (converged(r.wlo, r.whi, c.conv_width)) begin
          r = close_search(r, now);
        end else begin
          r.psize = next_size(r.wlo, r.whi, c.conv_width);
        end
      end
    end else if (r.mode == ModeComplete) begin
      // re-validation failed
      r.mode  = ModeError;
      r.whi   = r.vmtu;
      r.wlo   = c.min_mtu;
      r.vmtu  = c.min_mtu;
      r.retry = '0;
    end
    return r;
  endfunction

  function automatic state_t acked(state_t s, mtu_t size, time_t now, cfg_t c);
    state_t r;
    r         = s;
    r.pending = 1'b0;
    r.streak  = '0;
    if (is_active(r.mode)) begin
      if (size > r.vmtu) begin
        r.vmtu = size;
        r.wlo  = size;
      end
      if (converged(r.wlo, r.whi, c.conv_width)) begin
        r = close_search(r, now);
      end else begin
        r.mode  = ModeSearching;
        r.retry = '0;
        r.psize = next_size(r.wlo, r.whi, c.conv_width);
      end
    end else if (r.mode == ModeComplete) begin
      r.comp_at = now;
    end else if (r.mode == ModeError) begin
      r.mode  = ModeSearching;
      r.retry = '0;
      r.psize = next_size(r.wlo, r.whi, c.conv_width);
    end
    return r;
  endfunction

  function automatic state_t too_big(state_t s, mtu_t size, cfg_t c);
    state_t r;
    r = s;
    if ((size >= c.min_mtu) && (size < r.vmtu)) begin
      r.vmtu = size;
      r.whi  = size;
      if (r.mode == ModeComplete) begin
        r.mode  = ModeSearching;
        r.retry = '0;
        r.psize = next_size(r.wlo, r.whi, c.conv_width);
      end
    end else if (size < c.min_mtu) begin
      r = black_hole(r, c);
    end
    return r;
  endfunction

  state_t  state_q, state_d;
  in_req_t req_q;
  logic    req_valid_q;
  snap_t   snap_q, snap_d;
  logic    snap_valid_q;
  logic    adv_snap, adv_req;
  time_t   since_probe;

  assign adv_snap   = !snap_valid_q || !snap_stall_i;
  assign adv_req    = !req_valid_q || adv_snap;
  assign in_stall_o = !adv_req;

  assign since_probe = time_t'(req_q.now - state_q.last_at);

  always_comb begin
    state_d = state_q;
    case (cmd_e'(req_q.cmd))
      CmdEnable: begin
        if (state_q.mode == ModeDisabled) begin
          state_d.vmtu    = cfg_i.min_mtu;
          state_d.streak  = '0;
          state_d.pending = 1'b0;
          state_d.mode    = ModeSearching;
          state_d.wlo     = cfg_i.min_mtu;
          state_d.whi     = cfg_i.mtu_ceiling;
          state_d.retry   = '0;
          state_d.psize   = next_size(cfg_i.min_mtu, cfg_i.mtu_ceiling, cfg_i.conv_width);
        end
      end
      CmdDisable: begin
        state_d.mode    = ModeDisabled;
        state_d.vmtu    = cfg_i.min_mtu;
        state_d.psize   = '0;
        state_d.pending = 1'b0;
      end
      CmdReset: begin
        // timestamps survive a reset request
        state_d.mode    = ModeDisabled;
        state_d.vmtu    = cfg_i.min_mtu;
        state_d.wlo     = cfg_i.min_mtu;
        state_d.whi     = cfg_i.mtu_ceiling;
        state_d.psize   = '0;
        state_d.retry   = '0;
        state_d.streak  = '0;
        state_d.pending = 1'b0;
      end
      CmdSent: begin
        state_d.psize   = req_q.size;
        state_d.last_at = req_q.now;
        state_d.pending = 1'b1;
        state_d.retry   = sat_inc(state_q.retry);
      end
      CmdAcked: state_d = acked(state_q, req_q.size, req_q.now, cfg_i);
      CmdLost:  state_d = lost(state_q, req_q.size, req_q.now, cfg_i);
      CmdTooBig: state_d = too_big(state_q, req_q.size, cfg_i);
      CmdTimeout: begin
        if ((state_q.mode != ModeDisabled) && state_q.pending &&
            (since_probe >= cfg_i.loss_wait)) begin
          state_d = lost(state_q, state_q.psize, req_q.now, cfg_i);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    snap_d.mode          = state_d.mode;
    snap_d.validated_mtu = state_d.vmtu;
    snap_d.probing_size  = state_d.psize;
    snap_d.probe_pending = state_d.pending;
    snap_d.last_probe_at = state_d.last_at;
    snap_d.completed_at  = state_d.comp_at;
    snap_d.now           = req_q.now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= ModeDisabled;
      state_q.vmtu    <= MinMtuRst;
      state_q.wlo     <= MinMtuRst;
      state_q.whi     <= MaxProbeMtuRst;
      state_q.psize   <= '0;
      state_q.retry   <= '0;
      state_q.streak  <= '0;
      state_q.pending <= 1'b0;
      state_q.last_at <= '0;
      state_q.comp_at <= '0;
      req_valid_q     <= 1'b0;
      snap_valid_q    <= 1'b0;
    end else begin
      if (adv_snap) begin
        snap_valid_q <= req_valid_q;
        if (req_valid_q) begin
          state_q <= state_d;
        end
      end
      if (adv_req) begin
        req_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_snap && req_valid_q) begin
      snap_q <= snap_d;
    end
    if (adv_req && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ===== design/pmtu_status.sv =====
// pmtu_status: result stage of the probe search controller
// forms probe offer, probe-now flag and next deadline from a state snapshot
// depends on pmtu_pkg
module pmtu_status import pmtu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     snap_valid_i,
  output logic     snap_stall_o,
  input  snap_t    snap_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  out_rsp_t rsp_q, rsp_d;
  logic     out_valid_q;
  logic     adv_out;
  time_t    since_probe, since_done;

  assign adv_out      = !out_valid_q || !out_stall_i;
  assign snap_stall_o = !adv_out;

  assign since_probe = time_t'(snap_i.now - snap_i.last_probe_at);
  assign since_done  = time_t'(snap_i.now - snap_i.completed_at);

  always_comb begin
    rsp_d                = '0;
    rsp_d.current_mtu    = snap_i.validated_mtu;
    rsp_d.in_flight      = snap_i.probe_pending;
    rsp_d.deadline_valid = 1'b1;
    case (snap_i.mode)
      ModeDisabled: begin
        rsp_d.mode           = ModeCodeDisabled;
        rsp_d.deadline_valid = 1'b0;
      end
      ModeBase: begin
        rsp_d.mode        = ModeCodeBase;
        rsp_d.probe_valid = (snap_i.probing_size != '0);
        rsp_d.probe_bytes = snap_i.probing_size;
        rsp_d.probe_now   = !snap_i.probe_pending;
        rsp_d.deadline    = snap_i.probe_pending ?
                            time_t'(snap_i.last_probe_at + cfg_i.loss_wait) :
                            time_t'(snap_i.last_probe_at + cfg_i.probe_gap);
      end
      ModeSearching: begin
        rsp_d.mode        = ModeCodeSearching;
        rsp_d.probe_valid = (snap_i.probing_size != '0);
        rsp_d.probe_bytes = snap_i.probing_size;
        rsp_d.probe_now   = !snap_i.probe_pending && (since_probe >= cfg_i.probe_gap);
        rsp_d.deadline    = snap_i.probe_pending ?
                            time_t'(snap_i.last_probe_at + cfg_i.loss_wait) :
                            time_t'(snap_i.last_probe_at + cfg_i.probe_gap);
      end
      ModeComplete: begin
        rsp_d.mode        = ModeCodeComplete;
        rsp_d.probe_valid = 1'b1;
        rsp_d.probe_bytes = snap_i.validated_mtu;
        rsp_d.probe_now   = !snap_i.probe_pending &&
                            (since_done >= cfg_i.revalidate_gap);
        rsp_d.deadline    = snap_i.probe_pending ?
                            time_t'(snap_i.last_probe_at + cfg_i.loss_wait) :
                            time_t'(snap_i.completed_at + cfg_i.revalidate_gap);
      end
      ModeError: begin
        rsp_d.mode      = ModeCodeError;
        rsp_d.probe_now = !snap_i.probe_pending && (since_probe >= cfg_i.loss_wait);
        rsp_d.deadline  = time_t'(snap_i.last_probe_at + cfg_i.loss_wait);
      end
      default: begin
        rsp_d.mode           = ModeCodeDisabled;
        rsp_d.deadline_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && snap_valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== design/pmtu_probe_search_controller_top.sv =====
// Path-MTU probe search controller. Each request carries a command, a probe or
// reported size and a tick timestamp; each request gives exactly one result with
// the mode, validated MTU, offered probe size, probe-now flag, in-flight flag and
// next deadline. A request is taken every cycle when the output is not stalled;
// the path is three registers deep (request register, state update into the
// state and snapshot registers, result register). Each request reads the state
// left by the one before it, which the state update stage writes into the state
// register as it loads the snapshot register.
// Configuration registers may only be written while no request is in flight.
// depends on pmtu_pkg, pmtu_cfg, pmtu_ctrl, pmtu_status
module pmtu_probe_search_controller_top import pmtu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_req_t                 in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_rsp_t                out_rsp_o
);

  cfg_t  cfg;
  snap_t snap;
  logic  snap_valid;
  logic  snap_stall;

  pmtu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pmtu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .snap_valid_o (snap_valid),
    .snap_stall_i (snap_stall),
    .snap_o       (snap)
  );

  pmtu_status u_status (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .snap_valid_i (snap_valid),
    .snap_stall_o (snap_stall),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule
